// File: rtl/date_text_parser_core_assert.svh
// Assertion macros used by the date parser checker.
`ifndef DATE_TEXT_PARSER_CORE_ASSERT_SVH
`define DATE_TEXT_PARSER_CORE_ASSERT_SVH

// Clocked property with reset disable.
`define DTP_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A value holds across a stalled cycle.
`define DTP_HOLD(lbl, clk, rstn, vld, rdy, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) \
		((vld) && !(rdy)) |=> $stable(sig)) else $error(msg);

`endif

// File: rtl/dtp_pkg.sv
`default_nettype none

package dtp_pkg;

	// Default number width and the fixed result field width
	localparam int NUMBER_BITS_DEF = 16;
	localparam int RES_W = 16;
	localparam int MONTHS = 12;

	// Character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Result format and status codes
	typedef enum logic [1:0] {
		FMT_FULL  = 2'd0,
		FMT_SLASH = 2'd1,
		FMT_ABBR  = 2'd2
	} fmt_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MONTH   = 2'd1,
		ST_MISSING = 2'd2,
		ST_OVER    = 2'd3
	} status_t;

	// Number reader phase
	typedef enum logic [1:0] {
		PH_WS    = 2'd0,
		PH_SIGN  = 2'd1,
		PH_DIGIT = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	typedef struct packed {
		logic neg;
		logic got;
		logic over;
	} rdr_flags_t;

	typedef struct packed {
		logic [RES_W-1:0] val;
		status_t          st;
	} num_res_t;

	// Month names, right aligned, first letter in the top used byte
	localparam logic [71:0] MONTH_STR [MONTHS] = '{
		72'("January"), 72'("February"), 72'("March"), 72'("April"),
		72'("May"), 72'("June"), 72'("July"), 72'("August"),
		72'("September"), 72'("October"), 72'("November"), 72'("December")
	};
	localparam logic [3:0] MONTH_LEN [MONTHS] = '{
		4'd7, 4'd8, 4'd5, 4'd5, 4'd3, 4'd4, 4'd4, 4'd6, 4'd9, 4'd7, 4'd8, 4'd8
	};

	// Character of month m at position pos, zero past its end
	function automatic logic [7:0] month_char(input int unsigned m, input logic [3:0] pos);
		logic [71:0] s;
		int unsigned len;
		s = MONTH_STR[m];
		len = int'(MONTH_LEN[m]);
		if (int'(pos) < len)
			return s[8*(len-1-int'(pos)) +: 8];
		else
			return 8'h00;
	endfunction

	// Final value and status of one number reader
	function automatic num_res_t take_num(input logic [RES_W-1:0] value,
			input rdr_flags_t fl, input logic present, input logic [RES_W-1:0] limit);
		num_res_t r;
		r.val = '0;
		r.st = ST_OK;
		if (!present || !fl.got) begin
			r.st = ST_MISSING;
		end else if (fl.neg) begin
			if (value != '0)
				r.st = ST_OVER;
		end else if (fl.over || value > limit) begin
			r.val = limit;
			r.st = ST_OVER;
		end else begin
			r.val = value;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/dtp_in_if.sv
`default_nettype none

interface dtp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_text;

	modport source(output valid, char_code, end_of_text, input ready);
	modport sink(input valid, char_code, end_of_text, output ready);
endinterface

`default_nettype wire

// File: rtl/dtp_out_if.sv
`default_nettype none

interface dtp_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] day_value;
	logic [3:0]  month_value;
	logic [15:0] year_value;
	logic [1:0]  format_kind;
	logic [1:0]  status_code;

	modport source(output valid, day_value, month_value, year_value, format_kind,
		status_code, input ready);
	modport sink(input valid, day_value, month_value, year_value, format_kind,
		status_code, output ready);
endinterface

`default_nettype wire

// File: rtl/dtp_reader.sv
`default_nettype none

// Decimal number reader: skips whitespace, takes one sign, then digits.
module dtp_reader
	import dtp_pkg::*;
#(
	parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  feed,
	input  wire logic                  start,
	input  wire logic                  clear,
	input  wire logic [7:0]            ch,
	output logic [((NUMBER_BITS >= RES_W) ? RES_W : NUMBER_BITS)-1:0] nxt_value,
	output rdr_flags_t                 nxt_flags
);

	localparam int VAL_W = (NUMBER_BITS >= RES_W) ? RES_W : NUMBER_BITS;

	phase_t            phase_q, phase_n;
	logic [VAL_W-1:0]  value_q;
	rdr_flags_t        flags_q;
	logic              is_ws, is_dig;
	logic [VAL_W+3:0]  prod;

	// Character classes and the times-ten update
	assign is_ws  = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
	assign is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign prod   = {value_q, 3'b000} + {2'b00, value_q, 1'b0} + {{VAL_W{1'b0}}, ch[3:0]};

	// Next reader state
	always_comb begin
		phase_n   = phase_q;
		nxt_value = value_q;
		nxt_flags = flags_q;
		if (feed) begin
			unique case (phase_q)
				PH_DONE: ;
				PH_WS, PH_SIGN, PH_DIGIT: begin
					if (phase_q == PH_WS && is_ws) begin
						phase_n = PH_WS;
					end else if (phase_q == PH_WS && (ch == CH_PLUS || ch == CH_MINUS)) begin
						nxt_flags.neg = (ch == CH_MINUS);
						phase_n = PH_SIGN;
					end else if (!is_dig) begin
						phase_n = PH_DONE;
					end else begin
						nxt_flags.got = 1'b1;
						phase_n = PH_DIGIT;
						if (!flags_q.over) begin
							if (prod[VAL_W+3:VAL_W] != 4'd0) begin
								nxt_value = '1;
								nxt_flags.over = 1'b1;
							end else begin
								nxt_value = prod[VAL_W-1:0];
							end
						end
					end
				end
				default: phase_n = phase_q;
			endcase
		end
		if (start) begin
			phase_n   = PH_WS;
			nxt_value = '0;
			nxt_flags = '0;
		end
	end

	// Reader registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WS;
			value_q <= '0;
			flags_q <= '0;
		end else if (en) begin
			if (clear) begin
				phase_q <= PH_WS;
				value_q <= '0;
				flags_q <= '0;
			end else begin
				phase_q <= phase_n;
				value_q <= nxt_value;
				flags_q <= nxt_flags;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/date_text_parser_core.sv
`default_nettype none

// Channel  Dir  Payload                                            Request ends
// -------  ---  -------------------------------------------------  ---------------
// chars    in   char_code[7:0], end_of_text                        valid && ready
// result   out  day_value, month_value, year_value, format_kind,   valid && ready
//               status_code
//
// One character is taken every cycle unless chars.ready is low; each passes an input
// register and one update stage, and a result is registered from its final character.
// The update stage holds all parse state and reruns it from the initial
// state after each result. Reset clears the parse state and both valid bits.
// chars.ready drops only while a final character waits behind a result that
// has not been taken.
module date_text_parser_core
	import dtp_pkg::*;
#(
	parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dtp_in_if.sink     chars,
	dtp_out_if.source  result
);

	localparam int VAL_W = (NUMBER_BITS >= RES_W) ? RES_W : NUMBER_BITS;
	localparam int NRDR = 6;
	localparam int RD_LEAD = 0;
	localparam int RD_SP1 = 1;
	localparam int RD_SL1 = 2;
	localparam int RD_SLN = 3;
	localparam int RD_COM = 4;
	localparam int RD_SPN = 5;
	localparam logic [RES_W-1:0] NUM_LIMIT = RES_W'({VAL_W{1'b1}});
	localparam logic [RES_W-1:0] MONTH_LIMIT = RES_W'(MONTHS);
	localparam logic [3:0] ABBR_LEN = 4'd3;
	localparam logic [3:0] TOK_MAX = 4'd15;

	// Input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;
	logic       adv;

	// Parse state
	logic [MONTHS-1:0] name_q, name_n, abbr_q, abbr_n;
	logic [3:0]        tok_q, tok_n;
	logic              space_q, comma_q, slash_q;
	logic              space_n, comma_n, slash_n;
	logic              is_sp, is_comma, is_slash;

	// Readers
	logic [NRDR-1:0]  feed, start;
	logic [VAL_W-1:0] rd_val [NRDR];
	rdr_flags_t       rd_fl [NRDR];

	// Result
	fmt_t        fmt_n;
	logic [3:0]  month_n;
	num_res_t    day_r, mon_r, year_r;
	status_t     st_n;
	logic        res_valid_q;
	logic [15:0] day_q, year_q;
	logic [3:0]  month_q;
	fmt_t        fmt_q;
	status_t     st_q;

	// Handshake: stall only a final character behind a waiting result
	assign adv = valid_s1 && (!end_s1 || !res_valid_q || result.ready);
	assign chars.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_code;
			end_s1  <= chars.end_of_text;
		end
	end

	// Delimiters and reader control
	assign is_sp    = (char_s1 == CH_SPACE);
	assign is_comma = (char_s1 == CH_COMMA);
	assign is_slash = (char_s1 == CH_SLASH);

	always_comb begin
		feed = '0;
		feed[RD_LEAD] = 1'b1;
		feed[RD_SP1]  = space_q;
		feed[RD_SPN]  = space_q;
		feed[RD_SL1]  = slash_q;
		feed[RD_SLN]  = slash_q;
		feed[RD_COM]  = comma_q;
		start = '0;
		start[RD_SP1] = is_sp && !space_q;
		start[RD_SPN] = is_sp;
		start[RD_SL1] = is_slash && !slash_q;
		start[RD_SLN] = is_slash;
		start[RD_COM] = is_comma && !comma_q;
	end

	for (genvar k = 0; k < NRDR; k++) begin : g_rdr
		dtp_reader #(.NUMBER_BITS(NUMBER_BITS)) u_rdr (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.feed     (feed[k]),
			.start    (start[k]),
			.clear    (end_s1),
			.ch       (char_s1),
			.nxt_value(rd_val[k]),
			.nxt_flags(rd_fl[k])
		);
	end

	// Month name match over the first token
	always_comb begin
		name_n  = name_q;
		abbr_n  = abbr_q;
		tok_n   = tok_q;
		space_n = space_q || is_sp;
		comma_n = comma_q || is_comma;
		slash_n = slash_q || is_slash;
		if (!space_q && !is_sp) begin
			for (int i = 0; i < MONTHS; i++) begin
				if (tok_q >= MONTH_LEN[i] || char_s1 != month_char(i, tok_q))
					name_n[i] = 1'b0;
				if (tok_q < ABBR_LEN && char_s1 != month_char(i, tok_q))
					abbr_n[i] = 1'b0;
			end
			if (tok_q < TOK_MAX)
				tok_n = tok_q + 4'd1;
		end
	end

	// Result from the updated state
	always_comb begin
		if (comma_n)
			fmt_n = FMT_FULL;
		else if (slash_n)
			fmt_n = FMT_SLASH;
		else
			fmt_n = FMT_ABBR;

		month_n = 4'd0;
		for (int i = 0; i < MONTHS; i++) begin
			if (fmt_n == FMT_FULL && name_n[i] && tok_n == MONTH_LEN[i])
				month_n = 4'(i + 1);
			if (fmt_n == FMT_ABBR && abbr_n[i] && tok_n == ABBR_LEN)
				month_n = 4'(i + 1);
		end

		if (fmt_n == FMT_SLASH) begin
			day_r  = take_num(RES_W'(rd_val[RD_LEAD]), rd_fl[RD_LEAD], 1'b1, NUM_LIMIT);
			mon_r  = take_num(RES_W'(rd_val[RD_SL1]), rd_fl[RD_SL1], 1'b1, MONTH_LIMIT);
			year_r = take_num(RES_W'(rd_val[RD_SLN]), rd_fl[RD_SLN], 1'b1, NUM_LIMIT);
		end else begin
			day_r  = take_num(RES_W'(rd_val[RD_SP1]), rd_fl[RD_SP1], space_n, NUM_LIMIT);
			mon_r.val = RES_W'(month_n);
			mon_r.st  = (month_n == 4'd0) ? ST_MONTH : ST_OK;
			if (fmt_n == FMT_FULL)
				year_r = take_num(RES_W'(rd_val[RD_COM]), rd_fl[RD_COM], 1'b1, NUM_LIMIT);
			else
				year_r = take_num(RES_W'(rd_val[RD_SPN]), rd_fl[RD_SPN], space_n, NUM_LIMIT);
		end

		// first fault in reading order
		if (fmt_n == FMT_SLASH) begin
			if (day_r.st != ST_OK)
				st_n = day_r.st;
			else if (mon_r.st != ST_OK)
				st_n = mon_r.st;
			else
				st_n = year_r.st;
		end else begin
			if (mon_r.st != ST_OK)
				st_n = mon_r.st;
			else if (day_r.st != ST_OK)
				st_n = day_r.st;
			else
				st_n = year_r.st;
		end
	end

	// Parse state registers, back to initial after each result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_q  <= '1;
			abbr_q  <= '1;
			tok_q   <= '0;
			space_q <= 1'b0;
			comma_q <= 1'b0;
			slash_q <= 1'b0;
		end else if (adv) begin
			if (end_s1) begin
				name_q  <= '1;
				abbr_q  <= '1;
				tok_q   <= '0;
				space_q <= 1'b0;
				comma_q <= 1'b0;
				slash_q <= 1'b0;
			end else begin
				name_q  <= name_n;
				abbr_q  <= abbr_n;
				tok_q   <= tok_n;
				space_q <= space_n;
				comma_q <= comma_n;
				slash_q <= slash_n;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && end_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && end_s1) begin
			day_q   <= day_r.val;
			month_q <= mon_r.val[3:0];
			year_q  <= year_r.val;
			fmt_q   <= fmt_n;
			st_q    <= st_n;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.day_value   = day_q;
	assign result.month_value = month_q;
	assign result.year_value  = year_q;
	assign result.format_kind = fmt_q;
	assign result.status_code = st_q;

endmodule

`default_nettype wire

// File: rtl/dtp_chk.sv
`default_nettype none

`include "date_text_parser_core_assert.svh"

// Port-level checks on the date parser.
module dtp_chk
	import dtp_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] day_value,
	input wire logic [3:0]  month_value,
	input wire logic [15:0] year_value,
	input wire logic [1:0]  format_kind,
	input wire logic [1:0]  status_code
);

	logic [39:0] res_bits;
	logic        name_fmt;
	logic        month_ok;

	assign res_bits = {day_value, month_value, year_value, format_kind, status_code};
	assign name_fmt = out_valid && (format_kind != FMT_SLASH);
	assign month_ok = ((month_value == 4'd0) == (status_code == ST_MONTH)) &&
		(month_value <= 4'd12);

	// A pending result stays up and unchanged
	`DTP_HOLD(a_out_hold, clk, arst_n, out_valid, out_ready, out_valid, "result dropped")
	`DTP_HOLD(a_out_stable, clk, arst_n, out_valid, out_ready, res_bits, "result changed")

	// Input backpressure only comes from a stalled result
	`DTP_ASSERT(a_in_stall, clk, arst_n, !in_ready |-> (out_valid && !out_ready), "input stalled")

	// Name formats: month found exactly when the month status is clear
	`DTP_ASSERT(a_month, clk, arst_n, name_fmt |-> month_ok, "month mismatch")

endmodule

bind date_text_parser_core dtp_chk u_dtp_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (chars.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.day_value  (result.day_value),
	.month_value(result.month_value),
	.year_value (result.year_value),
	.format_kind(result.format_kind),
	.status_code(result.status_code)
);

`default_nettype wire
